// File: hdl/assert_macros.svh
// Assertion macros for RTL files that check themselves; only the top level includes them.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define STR_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define STR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define STR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define STR_ASSERT(label, expr)
`define STR_ASSERT_IMPL(label, ante, cons)
`define STR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/str_pkg.sv
// Shared constants, types and helper functions of the sparse tap resampler.
// No dependencies; every other file but the assertion macro header imports this package.
package str_pkg;

    localparam int LINE_DEPTH  = 4096;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int POS_W       = 14;
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 18;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int OUT_IDX_W   = 12;
    localparam int OUT_MAX     = 4096;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = POS_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [CFG_W-1:0] line_length;
        logic             wrap_mode;
        logic [CFG_W-1:0] output_count;
    } cfg_t;

    typedef struct packed {
        logic                       is_tap;
        logic [LINE_AW-1:0]         addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CFG_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > CFG_W'(LINE_DEPTH))
            r = CFG_W'(LINE_DEPTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] eff_count(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > CFG_W'(OUT_MAX))
            r = CFG_W'(OUT_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

// File: hdl/str_if.sv
// Valid/ready channel interfaces for input items and result words.
// Depends on str_pkg for field widths.
interface str_item_if import str_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [POS_W-1:0]    tap_position;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [WEIGHT_W-1:0] tap_weight;
    logic                       last_tap;

    modport source (output valid, mode, tap_position, sample_in, tap_weight, last_tap,
                    input ready);
    modport sink (input valid, mode, tap_position, sample_in, tap_weight, last_tap,
                  output ready);
endinterface

interface str_result_if import str_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OUT_IDX_W-1:0]       out_index;
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       saturated;

    modport source (output valid, out_index, out_value, saturated, input ready);
    modport sink (input valid, out_index, out_value, saturated, output ready);
endinterface

// File: hdl/str_front.sv
// Front end: accepts items, drops out-of-line writes, bounds tap positions
// (clamp, or wrap through a bit-serial remainder unit). Depends on str_pkg, str_if.
module str_front import str_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    str_item_if.sink        item,
    input  q_stat_t         q_stat,
    output logic            push,
    output q_entry_t        push_data
);

    localparam logic [1:0] F_EMPTY = 2'd0;
    localparam logic [1:0] F_HOLD  = 2'd1;
    localparam logic [1:0] F_DIV   = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic                       mode_reg;
    logic signed [POS_W-1:0]    pos_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                       last_reg;
    logic [LINE_AW-1:0]         rem_reg, rem_next;
    logic [POS_W-1:0]           mag_reg, mag_next;
    logic [DIV_CNT_W-1:0]       cnt_reg, cnt_next;

    logic [CFG_W-1:0]   len;
    logic               neg;
    logic               in_line;
    logic               wr_ok;
    logic               need_div;
    logic [LINE_AW-1:0] hold_idx;
    logic [LINE_AW-1:0] wrap_idx;
    logic [LINE_AW:0]   trial;
    logic               push_req;
    logic [LINE_AW-1:0] tap_idx;

    assign len      = eff_len(cfg.line_length);
    assign neg      = pos_reg[POS_W-1];
    assign in_line  = !neg && (CFG_W'(pos_reg[POS_W-2:0]) < len);
    assign wr_ok    = !neg && (pos_reg[POS_W-2:0] < (POS_W-1)'(LINE_DEPTH));
    assign need_div = mode_reg && !in_line && cfg.wrap_mode;
    assign hold_idx = in_line ? LINE_AW'(pos_reg[POS_W-2:0])
                    : (neg ? '0 : LINE_AW'(len - CFG_W'(1)));
    assign wrap_idx = (neg && rem_reg != '0) ? LINE_AW'(len - CFG_W'(rem_reg)) : rem_reg;
    assign trial    = {rem_reg, mag_reg[POS_W-1]};

    assign item.ready = (state_reg == F_EMPTY);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        push_req   = 1'b0;
        tap_idx    = hold_idx;
        case (state_reg)
            F_EMPTY:
            begin
                if (item.valid)
                    state_next = F_HOLD;
            end
            F_HOLD:
            begin
                if (!mode_reg && !wr_ok)
                    state_next = F_EMPTY;
                else if (need_div)
                begin
                    rem_next   = '0;
                    mag_next   = neg ? POS_W'(~pos_reg + POS_W'(1)) : POS_W'(pos_reg);
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
                else
                begin
                    push_req = 1'b1;
                    if (!q_stat.full)
                        state_next = F_EMPTY;
                end
            end
            F_DIV:
            begin
                if (CFG_W'(trial) >= len)
                    rem_next = LINE_AW'(CFG_W'(trial) - len);
                else
                    rem_next = LINE_AW'(trial);
                mag_next = {mag_reg[POS_W-2:0], 1'b0};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                push_req = 1'b1;
                tap_idx  = wrap_idx;
                if (!q_stat.full)
                    state_next = F_EMPTY;
            end
            default:
            begin
                state_next = F_EMPTY;
            end
        endcase
    end

    assign push             = push_req && !q_stat.full;
    assign push_data.is_tap = mode_reg;
    assign push_data.addr   = mode_reg ? tap_idx : LINE_AW'(pos_reg);
    assign push_data.sample = sample_reg;
    assign push_data.weight = weight_reg;
    assign push_data.last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_EMPTY;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        mag_reg <= mag_next;
        cnt_reg <= cnt_next;
        if (item.valid && item.ready)
        begin
            mode_reg   <= item.mode;
            pos_reg    <= item.tap_position;
            sample_reg <= item.sample_in;
            weight_reg <= item.tap_weight;
            last_reg   <= item.last_tap;
        end
    end

endmodule

// File: hdl/str_queue.sv
// Short FIFO of classified words between the front and back ends.
// Depends on str_pkg.
module str_queue import str_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t pop_data,
    output q_stat_t  stat
);

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hdl/str_back.sv
// Back end: sample line memory, multiply, saturating accumulate, rounding and
// the result register. Depends on str_pkg, str_if.
module str_back import str_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  q_entry_t        pop_data,
    input  q_stat_t         q_stat,
    output logic            pop,
    str_result_if.source    result
);

    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];

    logic                       adv;
    logic                       s1_valid_reg, s1_last_reg;
    logic signed [WEIGHT_W-1:0] s1_weight_reg;
    logic signed [SAMPLE_W-1:0] rd_reg;
    logic                       s2_valid_reg, s2_last_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       s3_valid_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic                       res_valid_reg;
    logic [OUT_IDX_W-1:0]       res_index_reg;
    logic signed [SAMPLE_W-1:0] res_value_reg;
    logic                       res_sat_reg;
    logic [OUT_IDX_W-1:0]       cnt_reg, cnt_next;

    logic signed [ACC_W:0]          acc_wide;
    logic signed [ACC_W-1:0]        acc_sat;
    logic signed [ACC_W:0]          rnd_wide;
    logic [ACC_W-FRAC_W:0]          q_val;
    logic [ACC_W-FRAC_W-SAMPLE_W+1:0] q_hi;
    logic                           clip;
    logic signed [SAMPLE_W-1:0]     q_clipped;

    assign adv = !res_valid_reg || result.ready;
    assign pop = adv && !q_stat.empty;

    assign acc_wide = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);
    always_comb
    begin
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1])
            acc_sat = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            acc_sat = acc_wide[ACC_W-1:0];
        acc_next = acc_reg;
        if (adv && s2_valid_reg)
            acc_next = s2_last_reg ? '0 : acc_sat;
    end

    assign rnd_wide  = (ACC_W+1)'(sum_reg) + (ACC_W+1)'(1 <<< (FRAC_W - 1));
    assign q_val     = rnd_wide[ACC_W:FRAC_W];
    assign q_hi      = q_val[ACC_W-FRAC_W:SAMPLE_W-1];
    assign clip      = !((q_hi == '0) || (q_hi == '1));
    assign q_clipped = clip ? (q_val[ACC_W-FRAC_W] ? SAMPLE_MIN : SAMPLE_MAX)
                     : q_val[SAMPLE_W-1:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (adv && s3_valid_reg)
        begin
            if ((CFG_W'(cnt_reg) + CFG_W'(1)) >= eff_count(cfg.output_count))
                cnt_next = '0;
            else
                cnt_next = cnt_reg + OUT_IDX_W'(1);
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.out_index = res_index_reg;
    assign result.out_value = res_value_reg;
    assign result.saturated = res_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (adv)
            begin
                s1_valid_reg  <= pop && pop_data.is_tap;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg && s2_last_reg;
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_weight_reg <= pop_data.weight;
            s1_last_reg   <= pop_data.last;
            prod_reg      <= PROD_W'(s1_weight_reg) * PROD_W'(rd_reg);
            s2_last_reg   <= s1_last_reg;
            sum_reg       <= acc_sat;
            if (s3_valid_reg)
            begin
                res_index_reg <= cnt_reg;
                res_value_reg <= q_clipped;
                res_sat_reg   <= clip;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (pop_data.is_tap)
                rd_reg <= line_mem[pop_data.addr];
            else
                line_mem[pop_data.addr] <= pop_data.sample;
        end
    end

endmodule

// File: hdl/sparse_tap_resampler.sv
// Sparse tap resampler top level: config registers, front end, queue, back end.
// Throughput: the front end holds one item and takes no new one until it has pushed it; a
// tap outside the line in wrap mode first runs the 14-step bit-serial remainder unit
// in the front end. The last tap goes through queue, read, multiply, sum and result regs.
// Reset: line_length 4096, wrap_mode 0, output_count 4096, accumulator and output
// index zero; the sample line is not cleared and holds garbage until written.
`include "assert_macros.svh"

module sparse_tap_resampler import str_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    str_item_if.sink             item_ch,
    str_result_if.source         result_ch
);

    cfg_t     cfg_reg;
    q_stat_t  q_stat;
    logic     q_push;
    logic     q_pop;
    q_entry_t q_push_data;
    q_entry_t q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_length  <= CFG_W'(4096);
            cfg_reg.wrap_mode    <= 1'b0;
            cfg_reg.output_count <= CFG_W'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_LENGTH:  cfg_reg.line_length  <= cfg_data;
                CFG_WRAP_MODE:    cfg_reg.wrap_mode    <= cfg_data[0];
                CFG_OUTPUT_COUNT: cfg_reg.output_count <= cfg_data;
                default:          ;
            endcase
        end
    end

    str_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item      (item_ch),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    str_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    str_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pop_data (q_pop_data),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .result   (result_ch)
    );

    `STR_ASSERT_IMPL(a_no_push_full, q_push, !q_stat.full)
    `STR_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_stat.empty)
    `STR_ASSERT_NEXT(a_one_item_held, item_ch.valid && item_ch.ready, !item_ch.ready)

endmodule
